### design/prs_pkg.sv
package prs_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int PACKET_BITS_DEFAULT = 64;
   localparam int DATA_W              = 64;
   localparam int COUNT_W             = 5;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;

   localparam logic [1:0] CODE_OK          = 2'd0;
   localparam logic [1:0] CODE_INVALID     = 2'd1;
   localparam logic [1:0] CODE_UNAVAILABLE = 2'd2;
   localparam logic [1:0] CODE_FULL        = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic [DATA_W-1:0]  packet_data;
      logic [COUNT_W-1:0] discard_count;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_code;
      logic [DATA_W-1:0]  packet_out;
      logic [COUNT_W-1:0] stored_count;
      logic [COUNT_W-1:0] free_space;
      logic               is_full;
   } rsp_type;

   // outcome of one request, before the packet word comes back from the ram
   typedef struct packed {
      logic [1:0]         code;
      logic [COUNT_W-1:0] stored_count;
      logic [COUNT_W-1:0] free_space;
      logic               is_full;
      logic               do_read;
   } status_type;

endpackage

### design/prs_ram.sv
module prs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/prs_ctrl.sv
module prs_ctrl #(
   parameter int DEPTH       = 16,
   parameter int PACKET_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  prs_pkg::req_type         req,
   output prs_pkg::status_type      status,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [PACKET_BITS-1:0]   wr_data,
   output logic [$clog2(DEPTH)-1:0] rd_addr
);

   import prs_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int SW = (PW + 1 > COUNT_W) ? PW + 1 : COUNT_W;

   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] held_ff, held_in;

   logic [EW-1:0] held_ext, count_ext, free_ext, n_ext;
   logic [SW-1:0] rd_step, rd_sum, rd_wrap, wr_sum, wr_wrap;
   logic          take_write, take_read, take_discard;
   logic [1:0]    code;

   assign held_ext = EW'(held_ff);
   assign n_ext    = EW'(req.discard_count);

   // pointer sums stay below twice the depth, so one subtract wraps them
   assign rd_step = take_discard ? SW'(req.discard_count) : SW'(1);
   assign rd_sum  = SW'(rd_ptr_ff) + rd_step;
   assign rd_wrap = (rd_sum >= SW'(DEPTH)) ? rd_sum - SW'(DEPTH) : rd_sum;
   assign wr_sum  = SW'(wr_ptr_ff) + SW'(1);
   assign wr_wrap = (wr_sum >= SW'(DEPTH)) ? wr_sum - SW'(DEPTH) : wr_sum;

   always_comb begin
      take_write   = 1'b0;
      take_read    = 1'b0;
      take_discard = 1'b0;
      code         = CODE_INVALID;
      case (req.kind)
         KIND_WRITE: begin
            if (held_ext >= EW'(DEPTH)) begin
               code = CODE_FULL;
            end else begin
               take_write = 1'b1;
               code       = CODE_OK;
            end
         end
         KIND_READ: begin
            if (held_ext == '0) begin
               code = CODE_UNAVAILABLE;
            end else begin
               take_read = 1'b1;
               code      = CODE_OK;
            end
         end
         KIND_DISCARD: begin
            if (n_ext == '0) begin
               code = CODE_INVALID;
            end else if (n_ext > held_ext) begin
               code = CODE_UNAVAILABLE;
            end else begin
               take_discard = 1'b1;
               code         = CODE_OK;
            end
         end
         default: begin
            code = CODE_INVALID;
         end
      endcase
   end

   always_comb begin
      count_ext = held_ext;
      if (take_write) begin
         count_ext = held_ext + EW'(1);
      end else if (take_read) begin
         count_ext = held_ext - EW'(1);
      end else if (take_discard) begin
         count_ext = held_ext - n_ext;
      end
   end

   assign free_ext            = EW'(DEPTH) - count_ext;
   assign status.code         = code;
   assign status.stored_count = count_ext[COUNT_W-1:0];
   assign status.free_space   = free_ext[COUNT_W-1:0];
   assign status.is_full      = (count_ext == EW'(DEPTH));
   assign status.do_read      = take_read;

   assign held_in   = accept ? count_ext[CW-1:0] : held_ff;
   assign rd_ptr_in = (accept && (take_read || take_discard)) ? rd_wrap[PW-1:0] : rd_ptr_ff;
   assign wr_ptr_in = (accept && take_write) ? wr_wrap[PW-1:0] : wr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         held_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         held_ff   <= held_in;
      end
   end

   assign wr_en   = accept && take_write;
   assign wr_addr = wr_ptr_ff;
   assign wr_data = req.packet_data[PACKET_BITS-1:0];
   assign rd_addr = rd_ptr_ff;

endmodule

### design/packet_ring_store_unit.sv
// throughput: one request per cycle unless a stalled response holds stage a;
//   the ram read of the oldest word sets the extra stage, the response register
//   lets a new request in while one waits; stage a feeds the response register
// reset: synchronous, clears pointers, count and the valid flags; packet storage
//   is not cleared and needs no clearing pass
module packet_ring_store_unit #(
   parameter int DEPTH       = prs_pkg::DEPTH_DEFAULT,
   parameter int PACKET_BITS = prs_pkg::PACKET_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  prs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output prs_pkg::rsp_type rsp_data
);

   import prs_pkg::*;

   localparam int PW = $clog2(DEPTH);

   logic             accept;
   logic             a_move;
   status_type       status;
   logic             wr_en;
   logic [PW-1:0]    wr_addr;
   logic [PW-1:0]    rd_addr;
   logic [PACKET_BITS-1:0] wr_data;
   logic [PACKET_BITS-1:0] rd_data;

   logic             a_valid_ff, a_valid_in;
   status_type       a_status_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   assign a_move    = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && !a_move;
   assign accept    = req_valid && !req_stall;

   prs_ctrl #(
      .DEPTH       (DEPTH),
      .PACKET_BITS (PACKET_BITS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .status  (status),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr)
   );

   // read port only moves on a taken request, so its output holds with stage a
   prs_ram #(
      .WIDTH (PACKET_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign a_valid_in   = accept || (a_valid_ff && !a_move);
   assign rsp_valid_in = a_move || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_in.result_code  = a_status_ff.code;
      rsp_in.packet_out   = a_status_ff.do_read ? DATA_W'(rd_data) : '0;
      rsp_in.stored_count = a_status_ff.stored_count;
      rsp_in.free_space   = a_status_ff.free_space;
      rsp_in.is_full      = a_status_ff.is_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_status_ff <= status;
      end
      if (a_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
